### design/dee_pkg.sv
// ----------------------------------------------------------------------------
// dee_pkg
// Shared types and constants for the data EEPROM unlock controller.
// ----------------------------------------------------------------------------
package dee_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 256;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned SIZE_W          = 9;
  localparam int unsigned TICKS_W         = 16;

  localparam logic [SIZE_W-1:0]  ACTIVE_SIZE_RST = 9'd256;
  localparam logic [TICKS_W-1:0] WRITE_TICKS_RST = 16'd1000;

  localparam logic [BYTE_W-1:0] UNLOCK_KEY_A = 8'h55;
  localparam logic [BYTE_W-1:0] UNLOCK_KEY_B = 8'hAA;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register selects
  localparam logic [1:0] REG_CONTROL = 2'd0;
  localparam logic [1:0] REG_UNLOCK  = 2'd1;
  localparam logic [1:0] REG_DATA    = 2'd2;
  localparam logic [1:0] REG_ADDRESS = 2'd3;

  // configuration register indexes
  localparam logic CFG_ACTIVE_SIZE = 1'b0;
  localparam logic CFG_WRITE_TICKS = 1'b1;

  // control register bit positions
  localparam int unsigned CB_RD    = 0;
  localparam int unsigned CB_WR    = 1;
  localparam int unsigned CB_WREN  = 2;
  localparam int unsigned CB_WRERR = 3;
  localparam int unsigned CB_EEIF  = 4;

  typedef enum logic [4:0] {
    ST_UNARMED   = 5'b00001,
    ST_NOT_READY = 5'b00010,
    ST_HAVE_55   = 5'b00100,
    ST_READY     = 5'b01000,
    ST_WRITING   = 5'b10000
  } dee_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [1:0]        register_select;
    logic [BYTE_W-1:0] write_data;
  } dee_req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] reg_byte;
    logic              interrupt_pulse;
    logic              busy_res;
  } dee_rsp_t;

  typedef struct packed {
    logic              ren;
    logic [BYTE_W-1:0] raddr;
    logic              wen;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
  } dee_mem_req_t;

endpackage

### design/dee_store.sv
// ----------------------------------------------------------------------------
// dee_store
// Byte store: one write and one registered read per cycle; entries never
// written read as zero.
// ----------------------------------------------------------------------------
module dee_store
  import dee_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dee_mem_req_t      mreq,
  output logic [BYTE_W-1:0] rdata
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);

  logic [BYTE_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;
  logic [BYTE_W-1:0]      rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (mreq.wen) begin
      mem[mreq.waddr[AW-1:0]] <= mreq.wdata;
    end
    if (mreq.ren) begin
      rd_q <= mem[mreq.raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (mreq.wen) begin
        valid[mreq.waddr[AW-1:0]] <= 1'b1;
      end
      if (mreq.ren) begin
        rd_valid <= valid[mreq.raddr[AW-1:0]];
      end
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

### design/dee_outq.sv
// ----------------------------------------------------------------------------
// dee_outq
// Two-entry result queue; takes a new beat while one result waits.
// ----------------------------------------------------------------------------
module dee_outq
  import dee_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  dee_rsp_t push_data,
  output logic     full,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output dee_rsp_t rsp
);

  dee_rsp_t   entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = rsp_valid && !rsp_stall;
  assign rsp_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign rsp       = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### design/data_eeprom_unlock_controller.sv
// ----------------------------------------------------------------------------
// data_eeprom_unlock_controller
// Each result beat is registered in the output queue behind earlier results.
// Throughput: one request beat per cycle while the output queue is not full.
// Reset (synchronous): clears the control state, the queue pointers and the
// store's entry valid bits; config returns to 256 bytes and 1000 ticks.
// ----------------------------------------------------------------------------
module data_eeprom_unlock_controller
  import dee_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  dee_req_t            req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output dee_rsp_t            rsp,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [TICKS_W-1:0]  cfg_data
);

  logic [SIZE_W-1:0]  active_size;
  logic [TICKS_W-1:0] write_ticks;

  dee_state_t        st, st_next;
  logic              wr_bit, wr_bit_next;
  logic              wren_bit, wren_bit_next;
  logic              wrerr_bit, wrerr_bit_next;
  logic              eeif_bit, eeif_bit_next;
  logic [BYTE_W-1:0] data_reg, data_reg_next;
  logic [BYTE_W-1:0] addr_reg, addr_reg_next;
  logic [BYTE_W-1:0] pend_addr, pend_addr_next;
  logic [BYTE_W-1:0] pend_data, pend_data_next;
  logic [TICKS_W-1:0] ticks_left, ticks_left_next;
  logic              ld_pend, ld_pend_next;

  logic              accept;
  logic              full;
  logic [BYTE_W-1:0] mem_rdata;
  logic [BYTE_W-1:0] data_eff;
  dee_mem_req_t      mreq;
  dee_rsp_t          res;

  assign accept    = req_valid && !req_stall;
  assign req_stall = full;
  assign cfg_ready = 1'b1;
  assign data_eff  = ld_pend ? mem_rdata : data_reg;

  function automatic logic present(input logic [BYTE_W-1:0] a,
                                   input logic [SIZE_W-1:0] sz);
    return ({1'b0, a} < sz) && ({1'b0, a} < SIZE_W'(STORE_DEPTH));
  endfunction

  always_comb begin
    logic v_rd, v_wr, v_wren;
    v_rd   = req.write_data[CB_RD];
    v_wr   = req.write_data[CB_WR];
    v_wren = req.write_data[CB_WREN];

    st_next         = st;
    wr_bit_next     = wr_bit;
    wren_bit_next   = wren_bit;
    wrerr_bit_next  = wrerr_bit;
    eeif_bit_next   = eeif_bit;
    data_reg_next   = data_eff;
    addr_reg_next   = addr_reg;
    pend_addr_next  = pend_addr;
    pend_data_next  = pend_data;
    ticks_left_next = ticks_left;
    ld_pend_next    = 1'b0;
    mreq            = '0;
    mreq.raddr      = addr_reg;
    mreq.waddr      = pend_addr;
    mreq.wdata      = pend_data;
    res             = '0;

    if (accept) begin
      unique case (req.operation)
        OP_WRITE: begin
          unique case (req.register_select)
            REG_CONTROL: begin
              if (v_wren) begin
                if (st == ST_UNARMED) begin
                  st_next = ST_NOT_READY;
                end else if (v_wr && !v_rd && st == ST_READY) begin
                  wr_bit_next     = 1'b1;
                  pend_addr_next  = addr_reg;
                  pend_data_next  = data_eff;
                  ticks_left_next = write_ticks;
                  st_next         = ST_WRITING;
                end
              end else if (st != ST_WRITING) begin
                st_next = ST_UNARMED;
              end
              wren_bit_next  = v_wren;
              wrerr_bit_next = req.write_data[CB_WRERR];
              eeif_bit_next  = req.write_data[CB_EEIF];
              if (v_rd && !v_wr && !wr_bit_next) begin
                st_next = ST_UNARMED;
                if (present(addr_reg, active_size)) begin
                  mreq.ren     = 1'b1;
                  ld_pend_next = 1'b1;
                end
              end
            end
            REG_UNLOCK: begin
              if (st == ST_NOT_READY && req.write_data == UNLOCK_KEY_A) begin
                st_next = ST_HAVE_55;
              end else if (st == ST_HAVE_55 && req.write_data == UNLOCK_KEY_B) begin
                st_next = ST_READY;
              end else if (st == ST_HAVE_55 || st == ST_READY) begin
                st_next = ST_NOT_READY;
              end
            end
            REG_DATA:    data_reg_next = req.write_data;
            REG_ADDRESS: addr_reg_next = req.write_data;
            default: ;
          endcase
        end
        OP_READ: begin
          unique case (req.register_select)
            REG_CONTROL: res.reg_byte = {3'b000, eeif_bit, wrerr_bit, wren_bit,
                                         wr_bit, 1'b0};
            REG_DATA:    res.reg_byte = data_eff;
            REG_ADDRESS: res.reg_byte = addr_reg;
            default:     res.reg_byte = '0;
          endcase
        end
        OP_TICK: begin
          if (st == ST_WRITING) begin
            if (ticks_left <= TICKS_W'(1)) begin
              ticks_left_next     = '0;
              mreq.wen            = present(pend_addr, active_size);
              wr_bit_next         = 1'b0;
              eeif_bit_next       = 1'b1;
              res.interrupt_pulse = 1'b1;
              st_next             = wren_bit ? ST_NOT_READY : ST_UNARMED;
            end else begin
              ticks_left_next = ticks_left - TICKS_W'(1);
            end
          end
        end
        default: ;
      endcase
      res.busy_res = (st_next == ST_WRITING);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size <= ACTIVE_SIZE_RST;
      write_ticks <= WRITE_TICKS_RST;
      st          <= ST_UNARMED;
      wr_bit      <= 1'b0;
      wren_bit    <= 1'b0;
      wrerr_bit   <= 1'b0;
      eeif_bit    <= 1'b0;
      data_reg    <= '0;
      addr_reg    <= '0;
      pend_addr   <= '0;
      pend_data   <= '0;
      ticks_left  <= '0;
      ld_pend     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACTIVE_SIZE: active_size <= cfg_data[SIZE_W-1:0];
          CFG_WRITE_TICKS: write_ticks <= cfg_data;
          default: ;
        endcase
      end
      st         <= st_next;
      wr_bit     <= wr_bit_next;
      wren_bit   <= wren_bit_next;
      wrerr_bit  <= wrerr_bit_next;
      eeif_bit   <= eeif_bit_next;
      data_reg   <= data_reg_next;
      addr_reg   <= addr_reg_next;
      pend_addr  <= pend_addr_next;
      pend_data  <= pend_data_next;
      ticks_left <= ticks_left_next;
      ld_pend    <= ld_pend_next;
    end
  end

  dee_store #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .mreq  (mreq),
    .rdata (mem_rdata)
  );

  dee_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef NO_ASSERTIONS
  a_wr_matches_state: assert property (@(posedge clk) disable iff (rst)
    wr_bit == (st == ST_WRITING))
    else $error("WR bit out of step with write state");

  a_load_follows_beat: assert property (@(posedge clk) disable iff (rst)
    ld_pend |-> $past(accept))
    else $error("store load pending without a request beat");

  a_ticks_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (st != ST_WRITING) |-> (ticks_left == '0))
    else $error("tick count nonzero while no write in progress");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mreq.ren && mreq.wen))
    else $error("store read and write issued together");
`endif

endmodule
